@@ hw/rtl/kbeq_pkg.sv @@
// Shared types, constants and helpers for the keyboard event queue.
package kbeq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LEVEL_W     = 5;
    localparam int LIMIT_W     = 16;

    localparam logic [LIMIT_W-1:0] HS_LIMIT_RESET = 16'd4096;
    localparam logic [LIMIT_W-1:0] TICKS_MAX      = 16'hFFFF;
    localparam logic [7:0]         KEY_CODE_MASK  = 8'h7F;
    localparam logic [7:0]         KEY_UP_BIT     = 8'h80;

    typedef enum logic [1:0] {
        MODE_KEY  = 2'd0,
        MODE_WIRE = 2'd1,
        MODE_TICK = 2'd2
    } mode_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] level_next;
    } q_stat_t;

    // key code -> wire byte: mask, release flag, invert, rotate left
    function automatic logic [7:0] make_wire(input logic [7:0] code, input logic released);
        logic [7:0] raw;
        logic [7:0] inv;
        raw = (code & KEY_CODE_MASK) | (released ? KEY_UP_BIT : 8'h00);
        inv = ~raw;
        return {inv[6:0], inv[7]};
    endfunction

endpackage

@@ hw/rtl/keyboard_event_queue_handshake_unit.sv @@
// Top level: keyboard event queue with host handshake wait and result stage.
//
// Input beats (s_*) are either enqueue requests or ticks, selected by
// s_tuser (0 key event, 1 wire byte, 2 tick, 3 no operation). Every input
// beat produces exactly one result beat on m_*, carrying the enqueue
// status, the delivered byte if any, the wait flag and the queue level.
// cfg_we/cfg_wdata write the handshake timeout limit (reset value 4096).
//
// Pipeline: the p1 stage waits for the registered read of the 16-entry
// queue memory, then the out stage drives m_*. Throughput: one beat per
// cycle while m_tready is high. All queue and wait state is updated in
// the cycle of acceptance, so a following beat sees it with no bubble.
//
// Reset clears pointers, fill count, wait state and the pipeline valids;
// queue entries are not cleared, none is read before it is written.
// When m_tready is low the result stage holds; the middle stage fills,
// and s_tready then drops until the result beat is taken.
module keyboard_event_queue_handshake_unit
    import kbeq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] data_byte, [8] key_released, [9] sp_line_level,
    // [10] host_register_full, [11] host_accepts, [15:12] zero
    input  logic [15:0]         s_tdata,
    // [1:0] mode
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] enqueue_ok, [1] deliver_valid, [9:2] deliver_byte, [10] waiting,
    // [15:11] queue_level
    output logic [15:0]         m_tdata,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata
);

    logic [7:0] in_byte;
    logic       in_release, in_sp, in_hfull, in_hacc;
    mode_t      in_mode;
    logic       s_fire;

    assign in_byte    = s_tdata[7:0];
    assign in_release = s_tdata[8];
    assign in_sp      = s_tdata[9];
    assign in_hfull   = s_tdata[10];
    assign in_hacc    = s_tdata[11];
    assign in_mode    = mode_t'(s_tuser);

    logic [LIMIT_W-1:0] limit_reg;
    logic               wait_reg, wait_next;
    logic               low_reg, low_next;
    logic [LIMIT_W-1:0] ticks_reg, ticks_next;

    q_ctrl_t    qctrl;
    q_stat_t    qstat;
    logic [7:0] q_wr_byte, q_rd_byte;

    logic enq_ok, deliver;

    // pipeline: p1 waits for the memory read, out drives the master port
    logic               p1_valid_reg;
    logic               p1_ok_reg, p1_dv_reg, p1_wait_reg;
    logic [LEVEL_W-1:0] p1_level_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;
    logic               p1_adv;

    assign p1_adv   = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_adv;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        logic hold;
        enq_ok     = 1'b0;
        deliver    = 1'b0;
        q_wr_byte  = in_byte;
        wait_next  = wait_reg;
        low_next   = low_reg;
        ticks_next = ticks_reg;
        hold       = 1'b0;
        case (in_mode)
            MODE_KEY: begin
                q_wr_byte = make_wire(in_byte, in_release);
                enq_ok    = !qstat.full;
            end
            MODE_WIRE: begin
                enq_ok = !qstat.full;
            end
            MODE_TICK: begin
                if (wait_reg) begin
                    if (!in_sp) begin
                        low_next = 1'b1;
                    end else if (low_reg) begin
                        wait_next  = 1'b0;
                        low_next   = 1'b0;
                        ticks_next = '0;
                    end else if (ticks_reg < TICKS_MAX) begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                    // timeout test runs on every tick of the wait
                    if (ticks_next > limit_reg) begin
                        wait_next  = 1'b0;
                        low_next   = 1'b0;
                        ticks_next = '0;
                    end
                    hold = wait_next;
                end
                if (!hold && !qstat.empty && !in_hfull && in_hacc) begin
                    deliver    = 1'b1;
                    wait_next  = 1'b1;
                    low_next   = 1'b0;
                    ticks_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign qctrl.push = s_fire && enq_ok;
    assign qctrl.pop  = s_fire && deliver;

    kbeq_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (qctrl),
        .wr_byte (q_wr_byte),
        .stat    (qstat),
        .rd_byte (q_rd_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= HS_LIMIT_RESET;
            wait_reg  <= 1'b0;
            low_reg   <= 1'b0;
            ticks_reg <= '0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (s_fire) begin
                wait_reg  <= wait_next;
                low_reg   <= low_next;
                ticks_reg <= ticks_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_ok_reg    <= enq_ok;
            p1_dv_reg    <= deliver;
            p1_wait_reg  <= wait_next;
            p1_level_reg <= LEVEL_W'(qstat.level_next);
        end
        // memory read data is stable while p1 holds: no pop without a new beat
        if (p1_adv) begin
            out_data_reg <= {p1_level_reg, p1_wait_reg,
                             (p1_dv_reg ? q_rd_byte : 8'h00), p1_dv_reg, p1_ok_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ hw/rtl/kbeq_queue.sv @@
// Byte FIFO: synchronous memory plus read/write pointers and fill count.
module kbeq_queue
    import kbeq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  q_ctrl_t    ctrl,
    input  logic [7:0] wr_byte,
    output q_stat_t    stat,
    output logic [7:0] rd_byte
);

    logic [7:0]       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       rd_byte_reg;

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (ctrl.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (ctrl.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        case ({ctrl.push, ctrl.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.level_next = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // one write port, one registered read port; a push and a pop never share a beat
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_ptr_reg] <= wr_byte;
        end
        if (ctrl.pop) begin
            rd_byte_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_byte = rd_byte_reg;

endmodule

@@ hw/rtl/kbeq_checker.sv @@
// Port-level checks for the keyboard event queue top level, with bind.
module kbeq_checker
    import kbeq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a delivery always starts a handshake wait
    a_dv_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[10])
        else $error("delivery without wait");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[9:2] == 8'h00)
        else $error("byte nonzero without delivery");

    a_ok_xor_dv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("enqueue and delivery in one beat");

    a_level_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:11] <= LEVEL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

endmodule

bind keyboard_event_queue_handshake_unit kbeq_checker u_kbeq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench for the keyboard event queue with host handshake wait.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kbeq_pkg::*;

    localparam logic [1:0] MODE_NOP  = 2'd3;
    localparam int         STALL_PCT = 38;
    localparam int         CEIL_RUN  = 40;

    typedef struct packed {
        logic               enq_ok;
        logic               dlv_valid;
        logic [7:0]         dlv_byte;
        logic               waiting;
        logic [LEVEL_W-1:0] level;
    } link_result_t;

    typedef struct packed {
        logic [1:0]   mode;
        logic [7:0]   data;
        logic         rel;
        logic         sp;
        logic         hfull;
        logic         hacc;
        logic         fixed;
        link_result_t res;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;

    // predictor state
    logic [7:0]          fifo_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    head_ptr;
    logic [PTR_W-1:0]    tail_ptr;
    logic [LEVEL_W-1:0]  fill_level;
    logic                hs_wait;
    logic                hs_low_seen;
    logic [LIMIT_W-1:0]  hs_ticks;
    logic [LIMIT_W-1:0]  hs_limit;

    link_result_t        expected_results[$];
    link_result_t        want_result;
    link_result_t        got_result;
    link_result_t        model_result;
    stim_row_t           directed_rows[$];
    int                  mismatch_count = 0;
    logic                row_fixed;
    link_result_t        row_result;
    logic                calm;
    logic                sp_level;
    int                  phase_limits [6] = '{0, 1, 3, 65535, 9, 2};

    keyboard_event_queue_handshake_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic link_result_t mk_result(input logic ok, input logic dv,
                                               input logic [7:0] db, input logic w,
                                               input logic [LEVEL_W-1:0] lvl);
        link_result_t r;
        r.enq_ok    = ok;
        r.dlv_valid = dv;
        r.dlv_byte  = db;
        r.waiting   = w;
        r.level     = lvl;
        return r;
    endfunction

    // mask to 7 bits, release flag on top, invert, rotate left by one
    function automatic logic [7:0] key_to_wire(input logic [7:0] code, input logic released);
        logic [7:0] flipped;
        flipped = ~{released, code[6:0]};
        return {flipped[6:0], flipped[7]};
    endfunction

    function automatic logic fifo_push(input logic [7:0] b);
        if (fill_level >= QUEUE_DEPTH)
            return 1'b0;
        fifo_mem[tail_ptr] = b;
        tail_ptr           = tail_ptr + 1'b1;
        fill_level         = fill_level + 1'b1;
        return 1'b1;
    endfunction

    function automatic void clear_wait();
        hs_wait     = 1'b0;
        hs_low_seen = 1'b0;
        hs_ticks    = '0;
    endfunction

    function automatic link_result_t advance_link(input logic [1:0] mode, input logic [7:0] data,
                                                  input logic rel, input logic sp,
                                                  input logic hfull, input logic hacc);
        link_result_t r;
        logic         go;
        r  = '0;
        go = 1'b1;
        if (mode == MODE_KEY) begin
            r.enq_ok = fifo_push(key_to_wire(data, rel));
        end else if (mode == MODE_WIRE) begin
            r.enq_ok = fifo_push(data);
        end else if (mode == MODE_TICK) begin
            if (hs_wait) begin
                if (!sp)
                    hs_low_seen = 1'b1;
                else if (hs_low_seen)
                    clear_wait();
                else if (hs_ticks != TICKS_MAX)
                    hs_ticks = hs_ticks + 1'b1;
                // timeout is tested on every tick, even while SP is low
                if (hs_ticks > hs_limit)
                    clear_wait();
                if (hs_wait)
                    go = 1'b0;
            end
            if (go && fill_level != 0 && !hfull && hacc) begin
                r.dlv_valid = 1'b1;
                r.dlv_byte  = fifo_mem[head_ptr];
                head_ptr    = head_ptr + 1'b1;
                fill_level  = fill_level - 1'b1;
                hs_wait     = 1'b1;
                hs_low_seen = 1'b0;
                hs_ticks    = '0;
            end
        end
        r.waiting = hs_wait;
        r.level   = fill_level;
        return r;
    endfunction

    task automatic check_beat(input link_result_t want, input link_result_t got);
        if (got.enq_ok !== want.enq_ok) begin
            $error("enqueue_ok: expected %0d, got %0d", want.enq_ok, got.enq_ok);
            mismatch_count++;
        end
        if (got.dlv_valid !== want.dlv_valid) begin
            $error("deliver_valid: expected %0d, got %0d", want.dlv_valid, got.dlv_valid);
            mismatch_count++;
        end
        if (got.dlv_byte !== want.dlv_byte) begin
            $error("deliver_byte: expected %02h, got %02h", want.dlv_byte, got.dlv_byte);
            mismatch_count++;
        end
        if (got.waiting !== want.waiting) begin
            $error("waiting: expected %0d, got %0d", want.waiting, got.waiting);
            mismatch_count++;
        end
        if (got.level !== want.level) begin
            $error("queue_level: expected %0d, got %0d", want.level, got.level);
            mismatch_count++;
        end
    endtask

    // predictor update and result check, all on sampled values at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            head_ptr   = '0;
            tail_ptr   = '0;
            fill_level = '0;
            hs_limit   = HS_LIMIT_RESET;
            clear_wait();
        end else begin
            if (cfg_we)
                hs_limit = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got_result = mk_result(m_tdata[0], m_tdata[1], m_tdata[9:2], m_tdata[10],
                                       m_tdata[15:11]);
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: %04h", m_tdata);
                    mismatch_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    check_beat(want_result, got_result);
                end
            end
            if (s_tvalid && s_tready) begin
                model_result = advance_link(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9],
                                            s_tdata[10], s_tdata[11]);
                expected_results.push_back(row_fixed ? row_result : model_result);
            end
        end
    end

    always @(negedge aclk) begin
        m_tready = aresetn && (calm || $urandom_range(99) >= STALL_PCT);
    end

    function automatic stim_row_t enq_row(input logic [1:0] mode, input logic [7:0] data,
                                          input logic rel);
        stim_row_t r;
        r       = '0;
        r.mode  = mode;
        r.data  = data;
        r.rel   = rel;
        // line and host fields are don't-care here; toggle them anyway
        r.sp    = 1'($urandom_range(1));
        r.hfull = 1'($urandom_range(1));
        r.hacc  = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic stim_row_t tick_row(input logic sp, input logic hfull, input logic hacc);
        stim_row_t r;
        r       = '0;
        r.mode  = MODE_TICK;
        r.data  = 8'($urandom_range(255));
        r.rel   = 1'($urandom_range(1));
        r.sp    = sp;
        r.hfull = hfull;
        r.hacc  = hacc;
        return r;
    endfunction

    function automatic stim_row_t with_result(input stim_row_t r, input link_result_t res);
        r.fixed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    task automatic send_beat(input stim_row_t r);
        while (!calm && $urandom_range(99) < STALL_PCT)
            @(negedge aclk);
        s_tuser    = r.mode;
        s_tdata    = {4'b0, r.hacc, r.hfull, r.sp, r.rel, r.data};
        row_fixed  = r.fixed;
        row_result = r.res;
        s_tvalid   = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid  = 1'b0;
        row_fixed = 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain();
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // mostly ticks with SP in runs, so low-then-high handshakes happen;
    // enqueue bursts push the queue to full
    task automatic random_phase(input int n_items);
        int        burst;
        int        pick;
        stim_row_t r;
        burst = 0;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (burst > 0 || pick < 22) begin
                r = enq_row($urandom_range(1) ? MODE_KEY : MODE_WIRE, 8'($urandom_range(255)),
                            1'($urandom_range(1)));
                if (burst > 0)
                    burst--;
            end else if (pick < 28) begin
                burst = $urandom_range(20, 10);
                r = enq_row(MODE_WIRE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (pick < 33) begin
                r = enq_row(MODE_NOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                if ($urandom_range(99) < 30)
                    sp_level = ~sp_level;
                r = tick_row(sp_level, $urandom_range(99) < 20, $urandom_range(99) < 80);
            end
            send_beat(r);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_TICK;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        row_fixed = 1'b0;
        row_result = '0;
        calm      = 1'b0;
        sp_level  = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset state, encoding extremes, host refusals, handshake paths
        directed_rows.push_back(with_result(tick_row(1, 0, 1), mk_result(0, 0, 8'h00, 0, 0)));
        directed_rows.push_back(with_result(enq_row(MODE_NOP, 8'hFF, 1),
                                            mk_result(0, 0, 8'h00, 0, 0)));
        directed_rows.push_back(with_result(enq_row(MODE_KEY, 8'h00, 0),
                                            mk_result(1, 0, 8'h00, 0, 1)));
        directed_rows.push_back(with_result(enq_row(MODE_KEY, 8'hFF, 1),
                                            mk_result(1, 0, 8'h00, 0, 2)));
        directed_rows.push_back(enq_row(MODE_KEY, 8'hA5, 0));
        directed_rows.push_back(with_result(enq_row(MODE_WIRE, 8'h00, 0),
                                            mk_result(1, 0, 8'h00, 0, 4)));
        directed_rows.push_back(with_result(enq_row(MODE_WIRE, 8'hFF, 1),
                                            mk_result(1, 0, 8'h00, 0, 5)));
        directed_rows.push_back(with_result(tick_row(1, 1, 1), mk_result(0, 0, 8'h00, 0, 5)));
        directed_rows.push_back(with_result(tick_row(1, 0, 0), mk_result(0, 0, 8'h00, 0, 5)));
        directed_rows.push_back(with_result(tick_row(1, 0, 1), mk_result(0, 1, 8'hFF, 1, 4)));
        directed_rows.push_back(with_result(tick_row(1, 0, 1), mk_result(0, 0, 8'h00, 1, 4)));
        directed_rows.push_back(with_result(tick_row(0, 0, 1), mk_result(0, 0, 8'h00, 1, 4)));
        directed_rows.push_back(with_result(tick_row(0, 0, 1), mk_result(0, 0, 8'h00, 1, 4)));
        // SP back high ends the wait and the next byte goes out on the same tick
        directed_rows.push_back(with_result(tick_row(1, 0, 1), mk_result(0, 1, 8'h00, 1, 3)));
        directed_rows.push_back(tick_row(0, 0, 0));
        directed_rows.push_back(with_result(tick_row(1, 0, 0), mk_result(0, 0, 8'h00, 0, 3)));
        directed_rows.push_back(tick_row(1, 0, 1));
        directed_rows.push_back(enq_row(MODE_NOP, 8'h5A, 0));
        directed_rows.push_back(enq_row(MODE_KEY, 8'h7F, 0));
        directed_rows.push_back(enq_row(MODE_KEY, 8'h80, 1));
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        random_phase(100);
        foreach (phase_limits[i]) begin
            write_limit(LIMIT_W'(phase_limits[i]));
            calm = (i == 2);
            random_phase(150);
            calm = 1'b0;
        end

        // largest limit: a run of SP-high ticks does not time out the wait
        write_limit(TICKS_MAX);
        send_beat(tick_row(0, 0, 0));
        send_beat(tick_row(1, 0, 0));
        send_beat(enq_row(MODE_WIRE, 8'h3C, 0));
        send_beat(tick_row(1, 0, 1));
        calm = 1'b1;
        repeat (CEIL_RUN)
            send_beat(tick_row(1, 1'($urandom_range(1)), 1'($urandom_range(1))));
        calm = 1'b0;
        send_beat(tick_row(0, 0, 1));
        send_beat(tick_row(1, 0, 1));

        write_limit(HS_LIMIT_RESET);
        random_phase(60);

        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
